// ===== src/hwu_pkg.sv =====
// shared types and constants of the hit word unpacker
package hwu_pkg;

    localparam int WordW      = 32;
    localparam int TagW       = 8;
    localparam int StrideW    = 12;
    localparam int IdW        = 8;
    localparam int ChannelW   = 20;
    localparam int EnergyW    = 16;
    localparam int StampW     = 64;
    localparam int CountW     = 32;
    localparam int SkipW      = 30;
    localparam int RecWordW   = 4;
    localparam int CfgDataW   = 12;
    localparam int OutDataW   = 136;

    localparam logic [WordW-1:0]    FILL_MASK    = 32'hfff0_0000;
    localparam logic [WordW-1:0]    FILL_MARK    = 32'hadd0_0000;
    localparam logic [IdW-1:0]      SKIP_SUBMEM  = 8'hff;
    localparam logic [RecWordW-1:0] REC_TS_LOW   = 4'd2;
    localparam logic [RecWordW-1:0] REC_TS_HIGH  = 4'd3;
    localparam logic [RecWordW-1:0] REC_ENERGY   = 4'd8;
    localparam logic [RecWordW-1:0] REC_LAST     = 4'd10;
    localparam logic [TagW-1:0]     TAG_RESET    = 8'h34;
    localparam logic [StrideW-1:0]  STRIDE_RESET = 12'd1500;
    localparam logic [CountW-1:0]   COUNT_MAX    = 32'hffff_ffff;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_HEADER_TAG    = 1'b0,
        REG_MODULE_STRIDE = 1'b1
    } cfg_index_t;

    // parse phases, one-hot
    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_SIZE    = 5'b00010,
        PH_SKIP    = 5'b00100,
        PH_RECORD  = 5'b01000,
        PH_STOPPED = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [TagW-1:0]    header_tag;
        logic [StrideW-1:0] module_stride;
    } cfg_t;

    typedef struct packed {
        logic                hit;
        logic [ChannelW-1:0] channel;
        logic [EnergyW-1:0]  energy;
        logic [StampW-1:0]   timestamp;
        logic [CountW-1:0]   hit_index;
    } hit_t;

endpackage

// ===== src/hwu_parse.sv =====
// parse state machine and hit assembly for one buffer word
module hwu_parse
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [hwu_pkg::WordW-1:0]     word,
    input  logic                          last_word,
    input  hwu_pkg::cfg_t                 cfg,
    output hwu_pkg::hit_t                 result
);

    hwu_pkg::phase_t                   phase_reg, phase_next;
    logic [hwu_pkg::RecWordW-1:0]      rec_reg, rec_next;
    logic [hwu_pkg::SkipW-1:0]         skip_reg, skip_next;
    logic [hwu_pkg::IdW-1:0]           module_reg, module_next;
    logic [hwu_pkg::IdW-1:0]           submem_reg, submem_next;
    logic [hwu_pkg::EnergyW-1:0]       energy_reg, energy_next;
    logic [hwu_pkg::StampW-1:0]        stamp_reg, stamp_next;
    logic [hwu_pkg::CountW-1:0]        count_reg, count_next;
    logic [hwu_pkg::ChannelW-1:0]      product;
    logic [hwu_pkg::SkipW-1:0]         skip_dec;
    logic                              emit;

    // 8 x 12 product stays below 2**20, so does the sum with the sub-memory id
    assign product  = hwu_pkg::ChannelW'(module_reg * cfg.module_stride);
    assign skip_dec = skip_reg - hwu_pkg::SkipW'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        rec_next    = rec_reg;
        skip_next   = skip_reg;
        module_next = module_reg;
        submem_next = submem_reg;
        energy_next = energy_reg;
        stamp_next  = stamp_reg;
        count_next  = count_reg;
        emit        = 1'b0;

        unique case (phase_reg)
            hwu_pkg::PH_HEADER:
            begin
                if ((word & hwu_pkg::FILL_MASK) != hwu_pkg::FILL_MARK)
                begin
                    module_next = word[23:16];
                    submem_next = word[31:24];
                    phase_next  = (word[7:0] == cfg.header_tag) ? hwu_pkg::PH_SIZE
                                                                : hwu_pkg::PH_STOPPED;
                end
            end
            hwu_pkg::PH_SIZE:
            begin
                if (word == '0)
                begin
                    phase_next = hwu_pkg::PH_STOPPED;
                end
                else if (submem_reg == hwu_pkg::SKIP_SUBMEM)
                begin
                    skip_next  = word[31:2];
                    phase_next = (word[31:2] != '0) ? hwu_pkg::PH_SKIP : hwu_pkg::PH_HEADER;
                end
                else
                begin
                    rec_next   = '0;
                    phase_next = hwu_pkg::PH_RECORD;
                end
            end
            hwu_pkg::PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = hwu_pkg::PH_HEADER;
                end
            end
            hwu_pkg::PH_RECORD:
            begin
                if (rec_reg == hwu_pkg::REC_TS_LOW)
                begin
                    stamp_next[31:0] = word;
                end
                else if (rec_reg == hwu_pkg::REC_TS_HIGH)
                begin
                    stamp_next[63:32] = word;
                end
                else if (rec_reg == hwu_pkg::REC_ENERGY)
                begin
                    energy_next = word[15:0];
                end
                if (rec_reg >= hwu_pkg::REC_LAST)
                begin
                    emit       = 1'b1;
                    rec_next   = '0;
                    phase_next = hwu_pkg::PH_HEADER;
                    if (count_reg != hwu_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + hwu_pkg::CountW'(1);
                    end
                end
                else
                begin
                    rec_next = rec_reg + hwu_pkg::RecWordW'(1);
                end
            end
            hwu_pkg::PH_STOPPED:
            begin
                phase_next = hwu_pkg::PH_STOPPED;
            end
            default:
            begin
                phase_next = hwu_pkg::PH_STOPPED;
            end
        endcase

        // buffer end restarts header search and clears the stop
        if (last_word)
        begin
            phase_next = hwu_pkg::PH_HEADER;
            rec_next   = '0;
            skip_next  = '0;
        end
    end

    assign result.hit       = emit;
    assign result.channel   = product + hwu_pkg::ChannelW'(submem_reg);
    assign result.energy    = energy_reg;
    assign result.timestamp = stamp_reg;
    assign result.hit_index = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hwu_pkg::PH_HEADER;
            rec_reg    <= '0;
            skip_reg   <= '0;
            module_reg <= '0;
            submem_reg <= '0;
            energy_reg <= '0;
            stamp_reg  <= '0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            rec_reg    <= rec_next;
            skip_reg   <= skip_next;
            module_reg <= module_next;
            submem_reg <= submem_next;
            energy_reg <= energy_next;
            stamp_reg  <= stamp_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/hwu_out.sv =====
// result register holding one hit until the downstream side takes it
module hwu_out
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  hwu_pkg::hit_t                   result,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [hwu_pkg::OutDataW-1:0]    m_tdata
);

    localparam int FieldW = hwu_pkg::ChannelW + hwu_pkg::EnergyW
                          + hwu_pkg::StampW + hwu_pkg::CountW;

    logic                               valid_reg, valid_next;
    logic [hwu_pkg::OutDataW-1:0]       data_reg, data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = result.hit;
            data_next  = {(hwu_pkg::OutDataW - FieldW)'(0), result.hit_index,
                          result.timestamp, result.energy, result.channel};
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ===== src/detector_word_stream_hit_unpacker_top.sv =====
// top level of the detector word stream hit unpacker
//
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+-----------------------------------
// s_axis    | in        | s_tvalid / s_tready | s_tdata = word, s_tlast = last_word
// m_axis    | out       | m_tvalid / m_tready | m_tdata = channel, energy, timestamp,
//           |           |                     |           hit_index
// cfg       | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one word per cycle sustained while m_tready stays high; a taken word is parsed
// from the input register and its hit, if any, is loaded into the result register
// the parse state updates only when the word moves from the input register to
// the result register, so stalls on m_tready leave it untouched
// while a hit waits in the result register the input register holds at most one
// word, and once it holds one s_tready stays low until the hit is taken
// reset clears parse state, hit counter and valid flags; registers go to
// header_tag 0x34 and module_stride 1500
module detector_word_stream_hit_unpacker_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input word stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hwu_pkg::WordW-1:0]       s_tdata,   // [31:0] word
    input  logic                            s_tlast,   // last_word
    // hit stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hwu_pkg::OutDataW-1:0]    m_tdata,   // [19:0] channel, [35:20] energy,
                                                       // [99:36] timestamp,
                                                       // [131:100] hit_index, rest zero
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  hwu_pkg::cfg_index_t             cfg_index,
    input  logic [hwu_pkg::CfgDataW-1:0]    cfg_data
);

    logic                               in_valid_reg, in_valid_next;
    logic [hwu_pkg::WordW-1:0]          in_word_reg;
    logic                               in_last_reg;
    logic                               s_accept;
    logic                               advance;
    hwu_pkg::cfg_t                      cfg_reg, cfg_next;
    hwu_pkg::hit_t                      result;

    // configuration registers, always writable
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                hwu_pkg::REG_HEADER_TAG:
                begin
                    cfg_next.header_tag = cfg_data[hwu_pkg::TagW-1:0];
                end
                hwu_pkg::REG_MODULE_STRIDE:
                begin
                    cfg_next.module_stride = cfg_data[hwu_pkg::StrideW-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_tag    <= hwu_pkg::TAG_RESET;
            cfg_reg.module_stride <= hwu_pkg::STRIDE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // word moves on when the result register is empty or being drained
    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_word_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    hwu_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .word      (in_word_reg),
        .last_word (in_last_reg),
        .cfg       (cfg_reg),
        .result    (result)
    );

    hwu_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== src/hwu_checker.sv =====
// port-level checks of the hit word unpacker, bound to the top level
module hwu_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [hwu_pkg::OutDataW-1:0]    m_tdata,
    input  logic                            cfg_ready
);

    logic m_take;

    assign m_take = m_tvalid && m_tready;

    // a held hit keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("hit payload changed while stalled");

    // with the result register empty, the input side is never blocked
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // hits taken on adjacent cycles carry successive indexes, saturating
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_take ##1 m_take |->
            (m_tdata[131:100] == $past(m_tdata[131:100]) + 32'd1) ||
            (m_tdata[131:100] == 32'hffff_ffff && $past(m_tdata[131:100]) == 32'hffff_ffff))
        else $error("hit index did not advance");

    // register writes are never refused
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration write refused");

endmodule

bind detector_word_stream_hit_unpacker_top hwu_checker u_hwu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

// ===== tb/tb_detector_word_stream_hit_unpacker_top.sv =====
// testbench for the hit unpacker: buffers of readout words in, hits checked against a predictor
`timescale 1ns / 1ps

module tb_detector_word_stream_hit_unpacker_top;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;     // covers the input and result registers plus margin
    localparam int WORDS_PER_PHASE = 150;
    localparam int LONG_HOLD       = 80;

    // kinds of buffer segment the random stimulus is built from
    typedef enum int {
        SEG_RECORD,
        SEG_SKIP,
        SEG_FILLER,
        SEG_BAD_TAG,
        SEG_ZERO_SIZE,
        SEG_NOISE
    } segment_t;

    typedef struct packed {
        logic [hwu_pkg::ChannelW-1:0] channel;
        logic [hwu_pkg::EnergyW-1:0]  energy;
        logic [hwu_pkg::StampW-1:0]   timestamp;
        logic [hwu_pkg::CountW-1:0]   hit_index;
    } hit_rec_t;

    // parse-state predictor plus the queue of hits it has announced
    class hit_scoreboard;
        logic [hwu_pkg::TagW-1:0]     tag_q;
        logic [hwu_pkg::StrideW-1:0]  stride_q;
        hwu_pkg::phase_t              phase_q;
        logic [hwu_pkg::RecWordW-1:0] rec_idx;
        logic [hwu_pkg::SkipW-1:0]    skip_q;
        logic [hwu_pkg::IdW-1:0]      mod_id;
        logic [hwu_pkg::IdW-1:0]      sub_id;
        logic [hwu_pkg::EnergyW-1:0]  energy_q;
        logic [hwu_pkg::StampW-1:0]   stamp_q;
        logic [hwu_pkg::CountW-1:0]   hits_so_far;
        hit_rec_t                     hit_q[$];
        int                           errors;
        int                           checked;
        int                           parsed;

        function new();
            tag_q       = hwu_pkg::TAG_RESET;
            stride_q    = hwu_pkg::STRIDE_RESET;
            phase_q     = hwu_pkg::PH_HEADER;
            rec_idx     = '0;
            skip_q      = '0;
            mod_id      = '0;
            sub_id      = '0;
            energy_q    = '0;
            stamp_q     = '0;
            hits_so_far = '0;
            errors      = 0;
            checked     = 0;
            parsed      = 0;
        endfunction

        function void set_reg(hwu_pkg::cfg_index_t idx, logic [hwu_pkg::CfgDataW-1:0] data);
            if (idx == hwu_pkg::REG_HEADER_TAG)
                tag_q = data[hwu_pkg::TagW-1:0];
            else
                stride_q = data[hwu_pkg::StrideW-1:0];
        endfunction

        function int pending();
            return hit_q.size();
        endfunction

        // one accepted input word
        function void note_word(logic [hwu_pkg::WordW-1:0] w, logic is_last);
            hit_rec_t h;
            logic     used;
            used = 1'b1;
            case (phase_q)
                hwu_pkg::PH_HEADER:
                begin
                    if ((w & hwu_pkg::FILL_MASK) == hwu_pkg::FILL_MARK)
                        used = 1'b0;
                    else
                    begin
                        mod_id  = w[23:16];
                        sub_id  = w[31:24];
                        phase_q = (w[7:0] == tag_q) ? hwu_pkg::PH_SIZE
                                                    : hwu_pkg::PH_STOPPED;
                    end
                end
                hwu_pkg::PH_SIZE:
                begin
                    if (w == '0)
                        phase_q = hwu_pkg::PH_STOPPED;
                    else if (sub_id == hwu_pkg::SKIP_SUBMEM)
                    begin
                        skip_q  = w[hwu_pkg::WordW-1:2];
                        phase_q = (skip_q != '0) ? hwu_pkg::PH_SKIP : hwu_pkg::PH_HEADER;
                    end
                    else
                    begin
                        rec_idx = '0;
                        phase_q = hwu_pkg::PH_RECORD;
                    end
                end
                hwu_pkg::PH_SKIP:
                begin
                    skip_q = skip_q - 1'b1;
                    if (skip_q == '0)
                        phase_q = hwu_pkg::PH_HEADER;
                end
                hwu_pkg::PH_RECORD:
                begin
                    if (rec_idx == hwu_pkg::REC_TS_LOW)
                        stamp_q[31:0] = w;
                    else if (rec_idx == hwu_pkg::REC_TS_HIGH)
                        stamp_q[63:32] = w;
                    else if (rec_idx == hwu_pkg::REC_ENERGY)
                        energy_q = w[hwu_pkg::EnergyW-1:0];
                    if (rec_idx >= hwu_pkg::REC_LAST)
                    begin
                        h.channel   = hwu_pkg::ChannelW'(mod_id) *
                                      hwu_pkg::ChannelW'(stride_q) +
                                      hwu_pkg::ChannelW'(sub_id);
                        h.energy    = energy_q;
                        h.timestamp = stamp_q;
                        h.hit_index = hits_so_far;
                        hit_q.push_back(h);
                        if (hits_so_far != hwu_pkg::COUNT_MAX)
                            hits_so_far = hits_so_far + 1'b1;
                        rec_idx = '0;
                        phase_q = hwu_pkg::PH_HEADER;
                    end
                    else
                        rec_idx = rec_idx + 1'b1;
                end
                default:
                begin
                    // stopped until the buffer ends
                    used    = 1'b0;
                    phase_q = hwu_pkg::PH_STOPPED;
                end
            endcase
            if (used)
                parsed++;
            if (is_last)
            begin
                phase_q = hwu_pkg::PH_HEADER;
                rec_idx = '0;
                skip_q  = '0;
            end
        endfunction

        // one accepted hit transaction
        function void check_hit(logic [hwu_pkg::OutDataW-1:0] data);
            hit_rec_t want;
            hit_rec_t got;
            got.channel   = data[hwu_pkg::ChannelW-1:0];
            got.energy    = data[hwu_pkg::ChannelW +: hwu_pkg::EnergyW];
            got.timestamp = data[hwu_pkg::ChannelW+hwu_pkg::EnergyW +: hwu_pkg::StampW];
            got.hit_index = data[hwu_pkg::ChannelW+hwu_pkg::EnergyW+hwu_pkg::StampW
                                 +: hwu_pkg::CountW];
            if (hit_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected hit, expected none, actual %h", $time, data);
                return;
            end
            want = hit_q.pop_front();
            checked++;
            if (got.channel !== want.channel)
            begin
                errors++;
                $display("%0t: channel mismatch, expected %h, actual %h",
                         $time, want.channel, got.channel);
            end
            if (got.energy !== want.energy)
            begin
                errors++;
                $display("%0t: energy mismatch, expected %h, actual %h",
                         $time, want.energy, got.energy);
            end
            if (got.timestamp !== want.timestamp)
            begin
                errors++;
                $display("%0t: timestamp mismatch, expected %h, actual %h",
                         $time, want.timestamp, got.timestamp);
            end
            if (got.hit_index !== want.hit_index)
            begin
                errors++;
                $display("%0t: hit_index mismatch, expected %h, actual %h",
                         $time, want.hit_index, got.hit_index);
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [hwu_pkg::WordW-1:0]       s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [hwu_pkg::OutDataW-1:0]    m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    hwu_pkg::cfg_index_t             cfg_index;
    logic [hwu_pkg::CfgDataW-1:0]    cfg_data;

    hit_scoreboard                   sb;
    logic [hwu_pkg::WordW-1:0]       frame_q[$];   // words of the buffer being sent
    bit                              tx_idle_on;
    bit                              rx_idle_on;
    int                              rx_hold;      // long receiver hold-off, in cycles
    int                              frames_sent;
    int                              words_sent;
    int                              settings;
    int                              cycles;

    detector_word_stream_hit_unpacker_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: long hold when asked, random stall bursts while rx_idle_on is set
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 6) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // hit monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_hit(m_tdata);
    end

    // one word transaction, with an optional idle burst ahead of it
    task automatic send_word(input logic [hwu_pkg::WordW-1:0] w, input logic is_last);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= is_last;
        do @(posedge clk); while (!s_tready);
        sb.note_word(w, is_last);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_word(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    // sender pauses until every hit is out and the pipeline is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input hwu_pkg::cfg_index_t idx,
                             input logic [hwu_pkg::CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    // upper bits of the tag write are don't-care and get random values
    task automatic configure(input logic [hwu_pkg::TagW-1:0] tag,
                             input logic [hwu_pkg::StrideW-1:0] stride);
        drain();
        write_reg(hwu_pkg::REG_HEADER_TAG, {4'($urandom_range(0, 15)), tag});
        write_reg(hwu_pkg::REG_MODULE_STRIDE, stride);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic add_segment(input segment_t kind);
        logic [hwu_pkg::WordW-1:0] size_w;
        int                        n;
        case (kind)
            SEG_RECORD, SEG_BAD_TAG:
            begin
                frame_q.push_back({8'($urandom_range(0, 254)), 8'($urandom), 8'($urandom),
                                   (kind == SEG_RECORD) ? sb.tag_q
                                                        : sb.tag_q ^ 8'($urandom_range(1, 255))});
                size_w = $urandom();
                if (size_w == '0)
                    size_w = 1;
                frame_q.push_back(size_w);
                // some record words look like filler and must still be consumed
                for (int i = 0; i <= int'(hwu_pkg::REC_LAST); i++)
                    frame_q.push_back(($urandom_range(0, 7) == 0)
                                      ? (hwu_pkg::FILL_MARK | 32'($urandom_range(0, 20'hfffff)))
                                      : 32'($urandom()));
            end
            SEG_SKIP:
            begin
                n      = $urandom_range(0, 4);
                size_w = {30'(n), 2'($urandom_range(0, 3))};
                if (size_w == '0)
                    size_w = 3;
                // a long skip runs into the buffer end
                if ($urandom_range(0, 5) == 0)
                    size_w = $urandom() | 32'h100;
                frame_q.push_back({hwu_pkg::SKIP_SUBMEM, 8'($urandom), 8'($urandom), sb.tag_q});
                frame_q.push_back(size_w);
                repeat (n) frame_q.push_back($urandom());
            end
            SEG_FILLER:
                repeat ($urandom_range(1, 4))
                    frame_q.push_back(hwu_pkg::FILL_MARK | 32'($urandom_range(0, 20'hfffff)));
            SEG_ZERO_SIZE:
            begin
                frame_q.push_back({8'($urandom), 8'($urandom), 8'($urandom), sb.tag_q});
                frame_q.push_back('0);
                frame_q.push_back($urandom());
            end
            default:
                repeat ($urandom_range(1, 6)) frame_q.push_back($urandom());
        endcase
    endtask

    // random buffers, half of their segments well-formed records on average, until enough words were sent
    task automatic run_random(input int words);
        int       goal;
        int       keep;
        int       r;
        segment_t kind;
        goal = words_sent + words;
        while (words_sent < goal)
        begin
            frame_q.delete();
            repeat ($urandom_range(1, 4))
            begin
                r = $urandom_range(0, 11);
                case (r)
                    6, 7:    kind = SEG_SKIP;
                    8:       kind = SEG_FILLER;
                    9:       kind = SEG_BAD_TAG;
                    10:      kind = SEG_ZERO_SIZE;
                    11:      kind = SEG_NOISE;
                    default: kind = SEG_RECORD;
                endcase
                add_segment(kind);
            end
            // buffer cut short somewhere in the middle
            if (frame_q.size() > 1 && $urandom_range(0, 4) == 0)
            begin
                keep = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > keep)
                    void'(frame_q.pop_back());
            end
            send_frame();
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = hwu_pkg::REG_HEADER_TAG;
        cfg_data    = '0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rx_hold     = 0;
        frames_sent = 0;
        words_sent  = 0;
        settings    = 1;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset register values
        // fillers, then a full record with all-ones timestamp and energy
        frame_q = '{32'hadd0_0000, 32'haddf_ffff, 32'h00ff_5a34, 32'hffff_ffff,
                    32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                    32'hadd1_2345, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                    32'hffff_ffff, 32'h0000_0000, 32'h1234_5678};
        send_frame();
        // all-zero word as a header has the wrong tag; rest of buffer ignored
        frame_q = '{32'h0000_0000, 32'h00ff_0134};
        send_frame();
        // zero-length skip, two-word skip over filler-like data, then zero size
        frame_q = '{32'hff00_0034, 32'h0000_0003, 32'hff07_0034, 32'h0000_000b,
                    32'hadd0_0001, 32'hffff_ffff, 32'h0503_0034, 32'h0000_0000,
                    32'h0000_0012};
        send_frame();

        run_random(WORDS_PER_PHASE / 2);

        // receiver holds off while the sender keeps offering records
        tx_idle_on = 1'b0;
        rx_hold    = LONG_HOLD;
        frame_q.delete();
        repeat (5) add_segment(SEG_RECORD);
        send_frame();
        tx_idle_on = 1'b1;
        drain();
        run_random(WORDS_PER_PHASE / 2);

        // register extremes: lowest tag and zero stride, then highest of both
        configure(8'h00, 12'd0);
        run_random(WORDS_PER_PHASE);
        configure(8'hff, 12'hfff);
        run_random(WORDS_PER_PHASE);

        // last part without idling on either side
        configure(8'($urandom), 12'd1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(WORDS_PER_PHASE);

        drain();
        $display("%0d buffers, %0d words sent, %0d words parsed, %0d hits checked",
                 frames_sent, words_sent, sb.parsed, sb.checked);
        $display("%0d register settings, long receiver hold and full drains included",
                 settings);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
